// ===== design/rbst_pkg.sv =====
// shared types and constants of the ring block sync tracker
// no dependencies; used by rbst_div and ring_block_sync_tracker_top
`timescale 1ns / 1ps

package rbst_pkg;

    localparam int STG_IDX_W  = 4;
    localparam int MAIN_IDX_W = 8;
    localparam int PEND_W     = 5;
    localparam int BB_W       = 12;
    localparam int SB_W       = 5;
    localparam int RB_W       = 9;
    localparam int POS_W      = 15;
    localparam int BYTE_W     = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 12;

    localparam logic [BB_W-1:0] MIN_BLOCK_BYTES    = 12'd32;
    localparam logic [BB_W-1:0] MAX_BLOCK_BYTES    = 12'd2048;
    localparam logic [SB_W-1:0] MAX_STAGING_BLOCKS = 5'd16;
    localparam logic [RB_W-1:0] MAX_MAIN_BLOCKS    = 9'd256;

    localparam logic [BB_W-1:0] RST_BLOCK_BYTES    = 12'd1024;
    localparam logic [SB_W-1:0] RST_STAGING_BLOCKS = 5'd2;
    localparam logic [RB_W-1:0] RST_RING_BLOCKS    = 9'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STAGING_BLOCKS = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RING_BLOCKS    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION      = 8'd3;

    localparam logic OP_START = 1'b0;
    localparam logic OP_EVENT = 1'b1;

    typedef struct packed {
        logic              start;
        logic [BYTE_W-1:0] dividend;
        logic [BB_W-1:0]   divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [BYTE_W-1:0] quotient;
    } t_div_rsp;

endpackage

// ===== design/ring_block_sync_tracker_top.sv =====
// ring block sync tracker: turns dma period events into block copy commands
// sequence: address set-up on every event, a divider pass for the staging index on a hit and
// a second one for the copy count on a capture hit, then one copy command per cycle while accepted
// input: one item at a time, taken only while idle; a start item clears indices and pending count
// reset: synchronous active low, clears indices and pending count, restores register defaults
// depends on rbst_pkg and rbst_div
`timescale 1ns / 1ps

module ring_block_sync_tracker_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // dma_offset[14:0], zero pad
    input  logic        i_s_axis_tuser,   // operation
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // staging_block[3:0], main_block[11:4], zero pad
    output logic        o_m_axis_tlast,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [rbst_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rbst_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_TOT,
        ST_MUL_FROM,
        ST_MUL_LEN,
        ST_REG1,
        ST_REG2,
        ST_DIV_POS,
        ST_WAIT_POS,
        ST_DIV_LEFT,
        ST_WAIT_LEFT,
        ST_CHECK,
        ST_EMIT
    } t_state;

    localparam int SI_W = rbst_pkg::STG_IDX_W;
    localparam int MI_W = rbst_pkg::MAIN_IDX_W;
    localparam int PW   = rbst_pkg::PEND_W;
    localparam int BW   = rbst_pkg::BYTE_W;
    localparam int MULW = rbst_pkg::SB_W + rbst_pkg::BB_W;

    t_state                       r_state;
    logic [rbst_pkg::BB_W-1:0]    r_cfg_bb;
    logic [rbst_pkg::SB_W-1:0]    r_cfg_sb;
    logic [rbst_pkg::RB_W-1:0]    r_cfg_rb;
    logic                         r_cfg_dir;
    logic [SI_W-1:0]              r_si;
    logic [MI_W-1:0]              r_mi;
    logic [PW-1:0]                r_pend;
    logic [rbst_pkg::POS_W-1:0]   r_pos;
    logic [BW-1:0]                r_total;
    logic [BW-1:0]                r_from;
    logic [BW-1:0]                r_len;
    logic [BW-1:0]                r_fend;
    logic [BW-1:0]                r_wrap;
    logic [BW-1:0]                r_left;

    logic [rbst_pkg::BB_W-1:0]    bb;
    logic [rbst_pkg::SB_W-1:0]    sb;
    logic [rbst_pkg::RB_W-1:0]    rb;
    logic [rbst_pkg::SB_W-1:0]    mul_a;
    logic [MULW-1:0]              mul_p;
    logic [BW:0]                  sum_fl;
    logic [BW-1:0]                pos_x;
    logic [BW-1:0]                left_c;
    logic [PW:0]                  pend_inc;
    logic [SI_W:0]                si_inc;
    logic [MI_W:0]                mi_inc;
    logic [BW:0]                  q_inc;
    logic                         s_acc;
    logic                         m_acc;
    rbst_pkg::t_div_req           div_req;
    rbst_pkg::t_div_rsp           div_rsp;

    always_comb begin
        if (r_cfg_bb < rbst_pkg::MIN_BLOCK_BYTES) begin
            bb = rbst_pkg::MIN_BLOCK_BYTES;
        end else if (r_cfg_bb > rbst_pkg::MAX_BLOCK_BYTES) begin
            bb = rbst_pkg::MAX_BLOCK_BYTES;
        end else begin
            bb = r_cfg_bb;
        end
        if (r_cfg_sb == '0) begin
            sb = rbst_pkg::SB_W'(1);
        end else if (r_cfg_sb > rbst_pkg::MAX_STAGING_BLOCKS) begin
            sb = rbst_pkg::MAX_STAGING_BLOCKS;
        end else begin
            sb = r_cfg_sb;
        end
        if (r_cfg_rb == '0) begin
            rb = rbst_pkg::RB_W'(1);
        end else if (r_cfg_rb > rbst_pkg::MAX_MAIN_BLOCKS) begin
            rb = rbst_pkg::MAX_MAIN_BLOCKS;
        end else begin
            rb = r_cfg_rb;
        end
    end

    // shared multiplier for ring size, region start and region length
    always_comb begin
        case (r_state)
            ST_MUL_TOT:  mul_a = sb;
            ST_MUL_FROM: mul_a = {1'b0, r_si};
            ST_MUL_LEN:  mul_a = r_pend;
            default:     mul_a = '0;
        endcase
        mul_p = mul_a * bb;
    end

    always_comb begin
        sum_fl = {1'b0, r_from} + {1'b0, r_len};
        pos_x  = {1'b0, r_pos};
        if (pos_x >= r_from && pos_x < r_fend) begin
            left_c = BW'(r_fend - pos_x + r_wrap);
        end else if (pos_x < r_wrap) begin
            left_c = r_wrap - pos_x;
        end else begin
            left_c = '0;
        end
        pend_inc = {1'b0, r_pend} + 1'b1;
        si_inc   = {1'b0, r_si} + 1'b1;
        mi_inc   = {1'b0, r_mi} + 1'b1;
        q_inc    = {1'b0, div_rsp.quotient} + 1'b1;
    end

    always_comb begin
        div_req.start    = (r_state == ST_DIV_POS) || (r_state == ST_DIV_LEFT);
        div_req.dividend = (r_state == ST_DIV_LEFT) ? r_left : pos_x;
        div_req.divisor  = bb;
    end

    rbst_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign s_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign m_acc = o_m_axis_tvalid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cfg_bb  <= rbst_pkg::RST_BLOCK_BYTES;
            r_cfg_sb  <= rbst_pkg::RST_STAGING_BLOCKS;
            r_cfg_rb  <= rbst_pkg::RST_RING_BLOCKS;
            r_cfg_dir <= 1'b0;
            r_si      <= '0;
            r_mi      <= '0;
            r_pend    <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    rbst_pkg::CFG_BLOCK_BYTES:    r_cfg_bb  <= i_cfg_data[rbst_pkg::BB_W-1:0];
                    rbst_pkg::CFG_STAGING_BLOCKS: r_cfg_sb  <= i_cfg_data[rbst_pkg::SB_W-1:0];
                    rbst_pkg::CFG_RING_BLOCKS:    r_cfg_rb  <= i_cfg_data[rbst_pkg::RB_W-1:0];
                    rbst_pkg::CFG_DIRECTION:      r_cfg_dir <= i_cfg_data[0];
                    default: ;
                endcase
            end
            case (r_state)
                ST_IDLE: begin
                    if (s_acc) begin
                        if (i_s_axis_tuser == rbst_pkg::OP_START) begin
                            r_si   <= '0;
                            r_mi   <= '0;
                            r_pend <= '0;
                        end else begin
                            r_pos <= i_s_axis_tdata[rbst_pkg::POS_W-1:0];
                            if ({1'b0, r_si} >= sb) begin
                                r_si <= '0;
                            end
                            if ({1'b0, r_mi} >= rb) begin
                                r_mi <= '0;
                            end
                            r_pend  <= (pend_inc > {1'b0, sb}) ? sb : pend_inc[PW-1:0];
                            r_state <= ST_MUL_TOT;
                        end
                    end
                end
                ST_MUL_TOT: begin
                    r_total <= mul_p[BW-1:0];
                    r_state <= ST_MUL_FROM;
                end
                ST_MUL_FROM: begin
                    r_from  <= mul_p[BW-1:0];
                    r_state <= ST_MUL_LEN;
                end
                ST_MUL_LEN: begin
                    r_len   <= mul_p[BW-1:0];
                    r_state <= ST_REG1;
                end
                ST_REG1: begin
                    if (sum_fl > {1'b0, r_total}) begin
                        r_fend <= r_total;
                        r_wrap <= BW'(sum_fl - {1'b0, r_total});
                    end else begin
                        r_fend <= sum_fl[BW-1:0];
                        r_wrap <= '0;
                    end
                    r_state <= ST_REG2;
                end
                ST_REG2: begin
                    r_left  <= left_c;
                    r_state <= (left_c != '0) ? ST_DIV_POS : ST_CHECK;
                end
                ST_DIV_POS: begin
                    r_state <= ST_WAIT_POS;
                end
                ST_WAIT_POS: begin
                    if (div_rsp.done) begin
                        r_si    <= (q_inc >= {{(BW + 1 - rbst_pkg::SB_W){1'b0}}, sb})
                                   ? '0 : q_inc[SI_W-1:0];
                        r_state <= r_cfg_dir ? ST_DIV_LEFT : ST_CHECK;
                    end
                end
                ST_DIV_LEFT: begin
                    r_state <= ST_WAIT_LEFT;
                end
                ST_WAIT_LEFT: begin
                    if (div_rsp.done) begin
                        r_pend  <= div_rsp.quotient[PW-1:0];
                        r_state <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    r_state <= (r_pend == '0) ? ST_IDLE : ST_EMIT;
                end
                ST_EMIT: begin
                    if (m_acc) begin
                        r_si   <= (si_inc >= sb) ? '0 : si_inc[SI_W-1:0];
                        r_mi   <= (mi_inc >= rb) ? '0 : mi_inc[MI_W-1:0];
                        r_pend <= r_pend - 1'b1;
                        if (r_pend == PW'(1)) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = (r_state == ST_EMIT);
    assign o_m_axis_tdata  = {4'd0, r_mi, r_si};
    assign o_m_axis_tlast  = (r_pend == PW'(1));

`ifndef SYNTHESIS
    a_stg_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ({1'b0, r_si} < sb)) else $error("staging index beyond ring");
    a_main_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ({1'b0, r_mi} < rb)) else $error("main index beyond ring");
    a_emit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r_pend != '0 && r_pend <= sb)) else $error("bad copy count");
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_axis_tready && o_m_axis_tvalid)) else $error("input taken during copy run");
    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_acc && o_m_axis_tlast) |=> (r_pend == '0 && o_s_axis_tready))
        else $error("pending count left after last copy");
`endif

endmodule

// ===== design/rbst_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on rbst_pkg for widths and the request/response structs
`timescale 1ns / 1ps

module rbst_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rbst_pkg::t_div_req i_req,
    output rbst_pkg::t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(rbst_pkg::BYTE_W + 1);

    logic                         r_busy;
    logic                         r_done;
    logic [CNT_W-1:0]             r_cnt;
    logic [rbst_pkg::BB_W-1:0]    r_rem;
    logic [rbst_pkg::BB_W-1:0]    r_dvs;
    logic [rbst_pkg::BYTE_W-1:0]  r_quo;

    logic [rbst_pkg::BB_W:0]      trial;
    logic                         take;

    always_comb begin
        trial = {r_rem, r_quo[rbst_pkg::BYTE_W-1]};
        take  = (trial >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(rbst_pkg::BYTE_W);
                r_rem  <= '0;
                r_dvs  <= i_req.divisor;
                r_quo  <= i_req.dividend;
            end else if (r_busy) begin
                r_rem <= take ? rbst_pkg::BB_W'(trial - {1'b0, r_dvs})
                              : trial[rbst_pkg::BB_W-1:0];
                r_quo <= {r_quo[rbst_pkg::BYTE_W-2:0], take};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("divider done without a running division");
    a_idle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |=> (r_busy || r_cnt == '0)) else $error("divider count left over");
    a_busy_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt != '0) else $error("divider running with zero count");
`endif

endmodule
